FILE: rtl/uum_pkg.sv
// Package: code point type and the uppercase mapping function.
`default_nettype none
package uum_pkg;

  localparam int unsigned CpWidth = 21;
  typedef logic [CpWidth-1:0] cp_t;

  // Single-point exceptions; these win over every range rule.
  function automatic logic point_lookup(input cp_t c, output cp_t up);
    logic hit;
    hit = 1'b1;
    up  = c;
    case (c)
      21'h00B5: up = 21'h039C; 21'h00F7: up = 21'h00F7; 21'h00FF: up = 21'h0178;
      21'h0130: up = 21'h0130; 21'h0131: up = 21'h0049; 21'h017F: up = 21'h0053;
      21'h0180: up = 21'h0243; 21'h0188: up = 21'h0187; 21'h018C: up = 21'h018B;
      21'h0192: up = 21'h0191; 21'h0195: up = 21'h01F6; 21'h0199: up = 21'h0198;
      21'h019A: up = 21'h023D; 21'h019E: up = 21'h0220; 21'h01A1: up = 21'h01A0;
      21'h01A3: up = 21'h01A2; 21'h01A5: up = 21'h01A4; 21'h01A8: up = 21'h01A7;
      21'h01AD: up = 21'h01AC; 21'h01B0: up = 21'h01AF; 21'h01B4: up = 21'h01B3;
      21'h01B6: up = 21'h01B5; 21'h01B9: up = 21'h01B8; 21'h01BD: up = 21'h01BC;
      21'h01BF: up = 21'h01F7; 21'h01C5: up = 21'h01C4; 21'h01C6: up = 21'h01C4;
      21'h01C8: up = 21'h01C7; 21'h01C9: up = 21'h01C7; 21'h01CB: up = 21'h01CA;
      21'h01CC: up = 21'h01CA; 21'h01DD: up = 21'h018E; 21'h01F2: up = 21'h01F1;
      21'h01F3: up = 21'h01F1; 21'h01F5: up = 21'h01F4; 21'h023C: up = 21'h023B;
      21'h023F: up = 21'h2C7E; 21'h0240: up = 21'h2C7F; 21'h0242: up = 21'h0241;
      21'h0247: up = 21'h0246; 21'h0249: up = 21'h0248; 21'h024B: up = 21'h024A;
      21'h024D: up = 21'h024C; 21'h024F: up = 21'h024E; 21'h0250: up = 21'h2C6F;
      21'h0251: up = 21'h2C6D; 21'h0252: up = 21'h2C70; 21'h0253: up = 21'h0181;
      21'h0254: up = 21'h0186; 21'h0256: up = 21'h0189; 21'h0257: up = 21'h018A;
      21'h0259: up = 21'h018F; 21'h025B: up = 21'h0190; 21'h025C: up = 21'hA7AB;
      21'h0260: up = 21'h0193; 21'h0261: up = 21'hA7AC; 21'h0263: up = 21'h0194;
      21'h0265: up = 21'hA78D; 21'h0266: up = 21'hA7AA; 21'h0268: up = 21'h0197;
      21'h0269: up = 21'h0196; 21'h026A: up = 21'hA7AE; 21'h026B: up = 21'h2C62;
      21'h026C: up = 21'hA7AD; 21'h026F: up = 21'h019C; 21'h0271: up = 21'h2C6E;
      21'h0272: up = 21'h019D; 21'h0275: up = 21'h019F; 21'h027D: up = 21'h2C64;
      21'h0280: up = 21'h01A6; 21'h0282: up = 21'hA7C5; 21'h0283: up = 21'h01A9;
      21'h0287: up = 21'hA7B1; 21'h0288: up = 21'h01AE; 21'h0289: up = 21'h0244;
      21'h028A: up = 21'h01B1; 21'h028B: up = 21'h01B2; 21'h028C: up = 21'h0245;
      21'h0292: up = 21'h01B7; 21'h029D: up = 21'hA7B2; 21'h029E: up = 21'hA7B0;
      21'h0345: up = 21'h0399; 21'h0371: up = 21'h0370; 21'h0373: up = 21'h0372;
      21'h0377: up = 21'h0376; 21'h037B: up = 21'h03FD; 21'h037C: up = 21'h03FE;
      21'h037D: up = 21'h03FF; 21'h03AC: up = 21'h0386; 21'h03AD: up = 21'h0388;
      21'h03AE: up = 21'h0389; 21'h03AF: up = 21'h038A; 21'h03C2: up = 21'h03A3;
      21'h03CC: up = 21'h038C; 21'h03CD: up = 21'h038E; 21'h03CE: up = 21'h038F;
      21'h03D0: up = 21'h0392; 21'h03D1: up = 21'h0398; 21'h03D5: up = 21'h03A6;
      21'h03D6: up = 21'h03A0; 21'h03D7: up = 21'h03CF; 21'h03D9: up = 21'h03D8;
      21'h03DB: up = 21'h03DA; 21'h03DD: up = 21'h03DC; 21'h03DF: up = 21'h03DE;
      21'h03F0: up = 21'h039A; 21'h03F1: up = 21'h03A1; 21'h03F2: up = 21'h03F9;
      21'h03F3: up = 21'h037F; 21'h03F5: up = 21'h0395; 21'h03F8: up = 21'h03F7;
      21'h03FB: up = 21'h03FA; 21'h04CF: up = 21'h04C0; 21'h10FB: up = 21'h10FB;
      21'h10FC: up = 21'h10FC; 21'h1C80: up = 21'h0412; 21'h1C81: up = 21'h0414;
      21'h1C82: up = 21'h041E; 21'h1C83: up = 21'h0421; 21'h1C84: up = 21'h0422;
      21'h1C85: up = 21'h0422; 21'h1C86: up = 21'h042A; 21'h1C87: up = 21'h0462;
      21'h1C88: up = 21'hA64A; 21'h1D79: up = 21'hA77D; 21'h1D7D: up = 21'h2C63;
      21'h1D8E: up = 21'hA7C6; 21'h1E9B: up = 21'h1E60;
      21'h1F70: up = 21'h1FBA; 21'h1F71: up = 21'h1FBB; 21'h1F72: up = 21'h1FC8;
      21'h1F73: up = 21'h1FC9; 21'h1F74: up = 21'h1FCA; 21'h1F75: up = 21'h1FCB;
      21'h1F76: up = 21'h1FDA; 21'h1F77: up = 21'h1FDB; 21'h1F78: up = 21'h1FF8;
      21'h1F79: up = 21'h1FF9; 21'h1F7A: up = 21'h1FEA; 21'h1F7B: up = 21'h1FEB;
      21'h1F7C: up = 21'h1FFA; 21'h1F7D: up = 21'h1FFB;
      21'h1FB2: up = 21'h1FB2; 21'h1FB3: up = 21'h1FBC; 21'h1FBE: up = 21'h0399;
      21'h1FC3: up = 21'h1FCC; 21'h1FE5: up = 21'h1FEC; 21'h1FF3: up = 21'h1FFC;
      21'h2C61: up = 21'h2C60; 21'h2C68: up = 21'h2C67; 21'h2C6A: up = 21'h2C69;
      21'h2C6C: up = 21'h2C6B; 21'h2C73: up = 21'h2C72; 21'h2C76: up = 21'h2C75;
      21'h2CEC: up = 21'h2CEB; 21'h2CEE: up = 21'h2CED; 21'h2CF3: up = 21'h2CF2;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  // Half-open range test [lo, hi).
  function automatic logic in_rng(input cp_t c, input cp_t lo, input cp_t hi);
    return (c >= lo) && (c < hi);
  endfunction

  // Ordered range rules; the first that matches supplies the offset.
  function automatic cp_t range_map(input cp_t c);
    logic odd, evn, lo8;
    odd = c[0];
    evn = ~c[0];
    lo8 = ~c[3];
    if (in_rng(c, 21'h0061, 21'h007B)) return c - 21'h20;
    if (in_rng(c, 21'h00E0, 21'h00FF)) return c - 21'h20;
    if (in_rng(c, 21'h0100, 21'h0130) && odd) return c - 21'd1;
    if (in_rng(c, 21'h0132, 21'h0138) && odd) return c - 21'd1;
    if (in_rng(c, 21'h0139, 21'h0149) && evn) return c - 21'd1;
    if (in_rng(c, 21'h014A, 21'h0178) && odd) return c - 21'd1;
    if (in_rng(c, 21'h0179, 21'h017F) && evn) return c - 21'd1;
    if (in_rng(c, 21'h0182, 21'h0186) && odd) return c - 21'd1;
    if (in_rng(c, 21'h01CD, 21'h01DD) && evn) return c - 21'd1;
    if (in_rng(c, 21'h01DE, 21'h01F0) && odd) return c - 21'd1;
    if (in_rng(c, 21'h01F8, 21'h0220) && odd) return c - 21'd1;
    if (in_rng(c, 21'h0222, 21'h0234) && odd) return c - 21'd1;
    if (in_rng(c, 21'h03B1, 21'h03CC)) return c - 21'h20;
    if (in_rng(c, 21'h03E0, 21'h03F0) && odd) return c - 21'd1;
    if (in_rng(c, 21'h0430, 21'h0450)) return c - 21'h20;
    if (in_rng(c, 21'h0450, 21'h0460)) return c - 21'h50;
    if (in_rng(c, 21'h0460, 21'h0482) && odd) return c - 21'd1;
    if (in_rng(c, 21'h048A, 21'h04C0) && odd) return c - 21'd1;
    if (in_rng(c, 21'h04C1, 21'h04CF) && evn) return c - 21'd1;
    if (in_rng(c, 21'h04D0, 21'h0530) && odd) return c - 21'd1;
    if (in_rng(c, 21'h0561, 21'h0587)) return c - 21'h30;
    if (in_rng(c, 21'h10D0, 21'h1100)) return c + 21'hBC0;
    if (in_rng(c, 21'h13F8, 21'h13FE)) return c - 21'd8;
    if (in_rng(c, 21'h1E00, 21'h1E96) && odd) return c - 21'd1;
    if (in_rng(c, 21'h1EA0, 21'h1F00) && odd) return c - 21'd1;
    // Greek extended letters with no capital
    if (in_rng(c, 21'h1F16, 21'h1F18)) return c;
    if (in_rng(c, 21'h1F46, 21'h1F48)) return c;
    if (in_rng(c, 21'h1F50, 21'h1F58) && evn) return c;
    if (in_rng(c, 21'h1FB4, 21'h1FB8)) return c;
    if (in_rng(c, 21'h1FC0, 21'h1FC3)) return c;
    if (in_rng(c, 21'h1FC4, 21'h1FC8)) return c;
    if (in_rng(c, 21'h1FD2, 21'h1FD8)) return c;
    if (in_rng(c, 21'h1FE2, 21'h1FE5)) return c;
    if (in_rng(c, 21'h1FE6, 21'h1FE8)) return c;
    if (in_rng(c, 21'h1FF0, 21'h1FF3)) return c;
    if (in_rng(c, 21'h1FF4, 21'h1FF8)) return c;
    if (in_rng(c, 21'h1F00, 21'h2000) && lo8) return c + 21'd8;
    if (in_rng(c, 21'h2170, 21'h2180)) return c - 21'h10;
    if (in_rng(c, 21'h24D0, 21'h24EA)) return c - 21'h1A;
    if (in_rng(c, 21'h2C30, 21'h2C60)) return c - 21'h30;
    if (in_rng(c, 21'h2C80, 21'h2CE4) && odd) return c - 21'd1;
    if (in_rng(c, 21'hA640, 21'hA66E) && odd) return c - 21'd1;
    if (in_rng(c, 21'hA680, 21'hA69C) && odd) return c - 21'd1;
    if (in_rng(c, 21'hA722, 21'hA730) && odd) return c - 21'd1;
    if (in_rng(c, 21'hA732, 21'hA770) && odd) return c - 21'd1;
    if (in_rng(c, 21'hA779, 21'hA77D) && evn) return c - 21'd1;
    if (in_rng(c, 21'hA780, 21'hA788) && odd) return c - 21'd1;
    if (in_rng(c, 21'hA790, 21'hA794) && odd) return c - 21'd1;
    if (in_rng(c, 21'hA79A, 21'hA7AA) && odd) return c - 21'd1;
    if (in_rng(c, 21'hA7B6, 21'hA7C4) && odd) return c - 21'd1;
    if (in_rng(c, 21'hA7C7, 21'hA7CB) && odd) return c - 21'd1;
    if (in_rng(c, 21'hFF41, 21'hFF5B)) return c - 21'h20;
    if (in_rng(c, 21'h10428, 21'h10450)) return c - 21'h28;
    if (in_rng(c, 21'h104D8, 21'h10500)) return c - 21'h28;
    // Mathematical alphanumerics: small letters sit 0x1A above capitals
    if (in_rng(c, 21'h1D41A, 21'h1D434) || in_rng(c, 21'h1D44E, 21'h1D468) ||
        in_rng(c, 21'h1D482, 21'h1D49C) || in_rng(c, 21'h1D4B6, 21'h1D4D0) ||
        in_rng(c, 21'h1D4EA, 21'h1D504) || in_rng(c, 21'h1D51E, 21'h1D538) ||
        in_rng(c, 21'h1D552, 21'h1D56C) || in_rng(c, 21'h1D586, 21'h1D5A0) ||
        in_rng(c, 21'h1D5BA, 21'h1D5D4) || in_rng(c, 21'h1D5EE, 21'h1D608) ||
        in_rng(c, 21'h1D622, 21'h1D63C) || in_rng(c, 21'h1D656, 21'h1D670) ||
        in_rng(c, 21'h1D68A, 21'h1D6A4) || in_rng(c, 21'h1D6C2, 21'h1D6DB) ||
        in_rng(c, 21'h1D6FC, 21'h1D715) || in_rng(c, 21'h1D736, 21'h1D74F) ||
        in_rng(c, 21'h1D770, 21'h1D789) || in_rng(c, 21'h1D7AA, 21'h1D7C3))
      return c - 21'h1A;
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/uum_map.sv
// Combinational uppercase mapping of one code point.
`default_nettype none
module uum_map
  import uum_pkg::*;
(
  input  wire cp_t cp,
  output cp_t      up
);

  cp_t pt_up;
  logic pt_hit;

  // Point exceptions take precedence over the range list
  always_comb begin
    pt_hit = point_lookup(cp, pt_up);
    up     = pt_hit ? pt_up : range_map(cp);
  end

endmodule
`default_nettype wire

FILE: rtl/unicode_uppercase_mapper.sv
// Top level: registered single-pass uppercase mapper for Unicode code points.
// Usage:
//   Input channel in_valid/in_ready/in_code_point carries one code point
//   (21 bits) per beat. Output channel out_valid/out_ready/out_upper_point
//   returns its simple uppercase mapping, or the value unchanged when no
//   rule applies. One result beat per input beat, in order.
//   Path: an accepted input beat passes through the input register, the
//   mapping logic and the result register before out_valid rises.
//   Throughput: one beat per cycle while out_ready is high; the input
//   register accepts whenever it is empty or its beat moves into the result
//   register in the same cycle.
//   Stall: when out_ready is low the result register holds, then the input
//   register fills and in_ready drops; nothing is lost.
//   Reset: rst_n low (synchronous) empties both registers; no other state.
`default_nettype none
module unicode_uppercase_mapper
  import uum_pkg::*;
(
  input  wire       clk,
  input  wire       rst_n,
  input  wire       in_valid,
  output logic      in_ready,
  input  wire cp_t  in_code_point,
  output logic      out_valid,
  input  wire       out_ready,
  output cp_t       out_upper_point
);

  logic s1_vld_r;
  cp_t  s1_cp_r;
  cp_t  s1_up;
  logic s1_adv;

  // Result register moves when empty or drained
  assign s1_adv   = ~out_valid | out_ready;
  assign in_ready = ~s1_vld_r | s1_adv;

  uum_map u_map (
    .cp(s1_cp_r),
    .up(s1_up)
  );

  // Input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_cp_r <= in_code_point;
    end
  end

  // Result stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_vld_r;
    end
    if (s1_adv && s1_vld_r) begin
      out_upper_point <= s1_up;
    end
  end

  // Result stays put while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_upper_point))
    else $error("result changed under stall");

  // A full input stage with a stalled output blocks intake
  a_block: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && out_valid && !out_ready |-> !in_ready)
    else $error("intake while full");

  // A loaded input stage shows up as a result next cycle when not stalled
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && s1_adv |=> out_valid)
    else $error("beat lost between stages");

endmodule
`default_nettype wire
